>>> design/lcdnw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared constants, codes, types and small tables of the character-LCD
// nibble write sequencer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

   localparam int DIGIT_SLOTS = 10;
   localparam int LAST_COLUMN = 19;
   localparam int NUM_W       = 32;
   localparam int CNT_W       = $clog2(NUM_W);
   localparam int BCD_DIGITS  = 10;
   localparam int IDX_W       = $clog2(BCD_DIGITS);
   localparam int DIGIT_TOP   = ((DIGIT_SLOTS < BCD_DIGITS) ? DIGIT_SLOTS : BCD_DIGITS) - 1;

   localparam logic [2:0] REQ_COMMAND = 3'd0;
   localparam logic [2:0] REQ_DATA    = 3'd1;
   localparam logic [2:0] REQ_GOTO    = 3'd2;
   localparam logic [2:0] REQ_NUMBER  = 3'd3;
   localparam logic [2:0] REQ_INIT    = 3'd4;
   localparam logic [2:0] REQ_CLEAR   = 3'd5;

   localparam logic [12:0] HOLD_US       = 13'd100;
   localparam logic [12:0] CLEAR_HOLD_US = 13'd2100;
   localparam logic [12:0] INIT0_HOLD_US = 13'd5100;
   localparam logic [12:0] INIT1_HOLD_US = 13'd250;
   localparam logic [14:0] POWER_UP_US   = 15'd20000;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CMD_CLEAR  = 8'h01;

   localparam logic [3:0] NIB_WAKE = 4'h3;
   localparam logic [3:0] NIB_FOUR = 4'h2;

   localparam logic [1:0] BSRC_VALUE = 2'd0;
   localparam logic [1:0] BSRC_GOTO  = 2'd1;
   localparam logic [1:0] BSRC_DIGIT = 2'd2;
   localparam logic [1:0] BSRC_FIXED = 2'd3;

   localparam logic [1:0] EMIT_HI    = 2'd0;
   localparam logic [1:0] EMIT_LO    = 2'd1;
   localparam logic [1:0] EMIT_FIXED = 2'd2;
   localparam logic [1:0] EMIT_ERROR = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [1:0]  sel;
      logic        rs;
      logic [3:0]  nibble;
      logic [14:0] wait_before;
      logic [12:0] wait_after;
      logic        last;
   } lcdnw_emit_type;

   typedef struct packed {
      logic           capture;
      logic           dabble;
      logic           idx_dec;
      logic           byte_load;
      logic [1:0]     byte_src;
      logic [7:0]     fixed_byte;
      lcdnw_emit_type emit;
   } lcdnw_cmd_type;

   typedef struct packed {
      logic goto_bad;
      logic conv_done;
      logic neg;
      logic digit_zero;
      logic high_zero;
      logic idx_zero;
   } lcdnw_status_type;

   function automatic logic [7:0] row_base(input logic [1:0] r);
      logic [7:0] b;
      case (r)
         2'd0:    b = 8'h80;
         2'd1:    b = 8'hC0;
         2'd2:    b = 8'h94;
         default: b = 8'hD4;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] init_byte(input logic [1:0] i);
      logic [7:0] b;
      case (i)
         2'd0:    b = 8'h28;
         2'd1:    b = 8'h0C;
         2'd2:    b = 8'h01;
         default: b = 8'h06;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

>>> design/lcdnw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_ctrl
// Sequencing state machine: walks each request through its nibble pulses and
// commands the datapath.
// ----------------------------------------------------------------------------
module lcdnw_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [2:0]                   req_type,
   input  wire lcdnw_pkg::lcdnw_status_type  status,
   output logic                              busy,
   output lcdnw_pkg::lcdnw_cmd_type          cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_LOAD      = 4'd1;
   localparam logic [3:0] ST_HI        = 4'd2;
   localparam logic [3:0] ST_LO        = 4'd3;
   localparam logic [3:0] ST_CONV      = 4'd4;
   localparam logic [3:0] ST_SIGN      = 4'd5;
   localparam logic [3:0] ST_SKIP      = 4'd6;
   localparam logic [3:0] ST_DIGIT     = 4'd7;
   localparam logic [3:0] ST_INIT_NIB  = 4'd8;
   localparam logic [3:0] ST_INIT_BYTE = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  kind_ff, kind_in;
   logic        phase_ff, phase_in;
   logic [1:0]  init_cnt_ff, init_cnt_in;
   logic        rs;
   logic [12:0] wait_low;

   assign busy = (state_ff != ST_IDLE);
   assign rs   = (kind_ff == lcdnw_pkg::REQ_DATA) || (kind_ff == lcdnw_pkg::REQ_NUMBER);

   always_comb begin
      if ((kind_ff == lcdnw_pkg::REQ_CLEAR) ||
          ((kind_ff == lcdnw_pkg::REQ_INIT) && (init_cnt_ff == 2'd2))) begin
         wait_low = lcdnw_pkg::CLEAR_HOLD_US;
      end else begin
         wait_low = lcdnw_pkg::HOLD_US;
      end
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      phase_in    = phase_ff;
      init_cnt_in = init_cnt_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               kind_in     = req_type;
               phase_in    = 1'b0;
               init_cnt_in = 2'd0;
               case (req_type)
                  lcdnw_pkg::REQ_COMMAND, lcdnw_pkg::REQ_DATA,
                  lcdnw_pkg::REQ_GOTO, lcdnw_pkg::REQ_CLEAR: state_in = ST_LOAD;
                  lcdnw_pkg::REQ_NUMBER:                     state_in = ST_CONV;
                  lcdnw_pkg::REQ_INIT:                       state_in = ST_INIT_NIB;
                  default:                                   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            if ((kind_ff == lcdnw_pkg::REQ_GOTO) && status.goto_bad) begin
               cmd.emit.valid = 1'b1;
               cmd.emit.sel   = lcdnw_pkg::EMIT_ERROR;
               cmd.emit.last  = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.byte_load = 1'b1;
               if (kind_ff == lcdnw_pkg::REQ_GOTO) begin
                  cmd.byte_src = lcdnw_pkg::BSRC_GOTO;
               end else if (kind_ff == lcdnw_pkg::REQ_CLEAR) begin
                  cmd.byte_src   = lcdnw_pkg::BSRC_FIXED;
                  cmd.fixed_byte = lcdnw_pkg::CMD_CLEAR;
               end else begin
                  cmd.byte_src = lcdnw_pkg::BSRC_VALUE;
               end
               state_in = ST_HI;
            end
         end
         ST_HI: begin
            cmd.emit.valid      = 1'b1;
            cmd.emit.sel        = lcdnw_pkg::EMIT_HI;
            cmd.emit.rs         = rs;
            cmd.emit.wait_after = lcdnw_pkg::HOLD_US;
            state_in            = ST_LO;
         end
         ST_LO: begin
            cmd.emit.valid      = 1'b1;
            cmd.emit.sel        = lcdnw_pkg::EMIT_LO;
            cmd.emit.rs         = rs;
            cmd.emit.wait_after = wait_low;
            case (kind_ff)
               lcdnw_pkg::REQ_NUMBER: begin
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                     state_in = ST_SKIP;
                  end else if (status.idx_zero) begin
                     cmd.emit.last = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     cmd.idx_dec = 1'b1;
                     state_in    = ST_DIGIT;
                  end
               end
               lcdnw_pkg::REQ_INIT: begin
                  if (init_cnt_ff == 2'd3) begin
                     cmd.emit.last = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     init_cnt_in = init_cnt_ff + 2'd1;
                     state_in    = ST_INIT_BYTE;
                  end
               end
               default: begin
                  cmd.emit.last = 1'b1;
                  state_in      = ST_IDLE;
               end
            endcase
         end
         ST_CONV: begin
            cmd.dabble = 1'b1;
            if (status.conv_done) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (status.neg) begin
               cmd.byte_load  = 1'b1;
               cmd.byte_src   = lcdnw_pkg::BSRC_FIXED;
               cmd.fixed_byte = lcdnw_pkg::CHAR_MINUS;
               state_in       = ST_HI;
            end else begin
               phase_in = 1'b1;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (status.digit_zero && status.high_zero && !status.idx_zero) begin
               cmd.idx_dec = 1'b1;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            cmd.byte_load = 1'b1;
            cmd.byte_src  = lcdnw_pkg::BSRC_DIGIT;
            state_in      = ST_HI;
         end
         ST_INIT_NIB: begin
            cmd.emit.valid = 1'b1;
            cmd.emit.sel   = lcdnw_pkg::EMIT_FIXED;
            case (init_cnt_ff)
               2'd0: begin
                  cmd.emit.nibble      = lcdnw_pkg::NIB_WAKE;
                  cmd.emit.wait_before = lcdnw_pkg::POWER_UP_US;
                  cmd.emit.wait_after  = lcdnw_pkg::INIT0_HOLD_US;
               end
               2'd1: begin
                  cmd.emit.nibble     = lcdnw_pkg::NIB_WAKE;
                  cmd.emit.wait_after = lcdnw_pkg::INIT1_HOLD_US;
               end
               2'd2: begin
                  cmd.emit.nibble     = lcdnw_pkg::NIB_WAKE;
                  cmd.emit.wait_after = lcdnw_pkg::HOLD_US;
               end
               default: begin
                  cmd.emit.nibble     = lcdnw_pkg::NIB_FOUR;
                  cmd.emit.wait_after = lcdnw_pkg::HOLD_US;
               end
            endcase
            if (init_cnt_ff == 2'd3) begin
               init_cnt_in = 2'd0;
               state_in    = ST_INIT_BYTE;
            end else begin
               init_cnt_in = init_cnt_ff + 2'd1;
            end
         end
         ST_INIT_BYTE: begin
            cmd.byte_load  = 1'b1;
            cmd.byte_src   = lcdnw_pkg::BSRC_FIXED;
            cmd.fixed_byte = lcdnw_pkg::init_byte(init_cnt_ff);
            state_in       = ST_HI;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         kind_ff     <= lcdnw_pkg::REQ_COMMAND;
         phase_ff    <= 1'b0;
         init_cnt_ff <= 2'd0;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         phase_ff    <= phase_in;
         init_cnt_ff <= init_cnt_in;
      end
   end

endmodule
`default_nettype wire

>>> design/lcdnw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_datapath
// Request field capture, bit-serial binary to BCD conversion, byte selection
// and the registered result word.
// ----------------------------------------------------------------------------
module lcdnw_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [7:0]                  req_byte_value,
   input  wire logic [7:0]                  req_row,
   input  wire logic [7:0]                  req_col,
   input  wire logic signed [31:0]          req_number,
   input  wire lcdnw_pkg::lcdnw_cmd_type    cmd,
   output lcdnw_pkg::lcdnw_status_type      status,
   output logic                             rsp_strobe,
   output logic                             rsp_drive,
   output logic                             rsp_rs,
   output logic [3:0]                       rsp_nibble,
   output logic [14:0]                      rsp_wait_before_us,
   output logic [12:0]                      rsp_wait_after_us,
   output logic                             rsp_status,
   output logic                             rsp_last
);

   logic [7:0]                                  byte_value_ff;
   logic [7:0]                                  row_ff;
   logic [7:0]                                  col_ff;
   logic                                        neg_ff;
   logic [lcdnw_pkg::NUM_W-1:0]                 mag_ff, mag_in;
   logic [lcdnw_pkg::CNT_W-1:0]                 bit_cnt_ff;
   logic [lcdnw_pkg::BCD_DIGITS-1:0][3:0]       bcd_ff, bcd_in, bcd_adj;
   logic [lcdnw_pkg::BCD_DIGITS*4:0]            bcd_wide;
   logic [lcdnw_pkg::IDX_W-1:0]                 dig_idx_ff;
   logic [7:0]                                  byte_ff, byte_in;
   logic [3:0]                                  cur_digit;
   logic [lcdnw_pkg::NUM_W-1:0]                 num_u;
   logic                                        high_zero;

   logic                                        strobe_ff;
   lcdnw_pkg::lcdnw_emit_type                   emit_ff;
   logic [3:0]                                  nibble_ff, nibble_in;

   assign num_u  = req_number;
   assign mag_in = num_u[lcdnw_pkg::NUM_W-1] ? ('0 - num_u) : num_u;

   always_comb begin
      for (int i = 0; i < lcdnw_pkg::BCD_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? (bcd_ff[i] + 4'd3) : bcd_ff[i];
      end
      bcd_wide = {bcd_adj, mag_ff[lcdnw_pkg::NUM_W-1]};
      bcd_in   = bcd_wide[lcdnw_pkg::BCD_DIGITS*4-1:0];
   end

   always_comb begin
      high_zero = 1'b1;
      for (int i = 0; i < lcdnw_pkg::BCD_DIGITS; i++) begin
         if ((i > lcdnw_pkg::DIGIT_TOP) && (bcd_ff[i] != 4'd0)) begin
            high_zero = 1'b0;
         end
      end
   end

   assign cur_digit = bcd_ff[dig_idx_ff];

   assign status.goto_bad   = (row_ff > 8'd3) || (col_ff > 8'(lcdnw_pkg::LAST_COLUMN));
   assign status.conv_done  = (bit_cnt_ff == lcdnw_pkg::CNT_W'(lcdnw_pkg::NUM_W - 1));
   assign status.neg        = neg_ff;
   assign status.digit_zero = (cur_digit == 4'd0);
   assign status.high_zero  = high_zero;
   assign status.idx_zero   = (dig_idx_ff == '0);

   always_comb begin
      case (cmd.byte_src)
         lcdnw_pkg::BSRC_VALUE: byte_in = byte_value_ff;
         lcdnw_pkg::BSRC_GOTO:  byte_in = lcdnw_pkg::row_base(row_ff[1:0]) + col_ff;
         lcdnw_pkg::BSRC_DIGIT: byte_in = lcdnw_pkg::CHAR_ZERO + {4'd0, cur_digit};
         default:               byte_in = cmd.fixed_byte;
      endcase
   end

   always_comb begin
      case (cmd.emit.sel)
         lcdnw_pkg::EMIT_HI:    nibble_in = byte_ff[7:4];
         lcdnw_pkg::EMIT_LO:    nibble_in = byte_ff[3:0];
         lcdnw_pkg::EMIT_FIXED: nibble_in = cmd.emit.nibble;
         default:               nibble_in = 4'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_value_ff <= req_byte_value;
         row_ff        <= req_row;
         col_ff        <= req_col;
         neg_ff        <= num_u[lcdnw_pkg::NUM_W-1];
         mag_ff        <= mag_in;
         bit_cnt_ff    <= '0;
         bcd_ff        <= '0;
         dig_idx_ff    <= lcdnw_pkg::IDX_W'(lcdnw_pkg::DIGIT_TOP);
      end else begin
         if (cmd.dabble) begin
            bcd_ff     <= bcd_in;
            mag_ff     <= {mag_ff[lcdnw_pkg::NUM_W-2:0], 1'b0};
            bit_cnt_ff <= bit_cnt_ff + lcdnw_pkg::CNT_W'(1);
         end
         if (cmd.idx_dec) begin
            dig_idx_ff <= dig_idx_ff - lcdnw_pkg::IDX_W'(1);
         end
      end
      if (cmd.byte_load) begin
         byte_ff <= byte_in;
      end
      if (cmd.emit.valid) begin
         emit_ff   <= cmd.emit;
         nibble_ff <= nibble_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit.valid;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_drive          = (emit_ff.sel != lcdnw_pkg::EMIT_ERROR);
   assign rsp_status         = (emit_ff.sel == lcdnw_pkg::EMIT_ERROR);
   assign rsp_rs             = emit_ff.rs;
   assign rsp_nibble         = nibble_ff;
   assign rsp_wait_before_us = emit_ff.wait_before;
   assign rsp_wait_after_us  = emit_ff.wait_after;
   assign rsp_last           = emit_ff.last;

endmodule
`default_nettype wire

>>> design/char_lcd_nibble_write_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns command, data, goto, number, init and clear requests into 4-bit
// character-LCD nibble pulses with their register select and wait times.
//
//   Channel   Ports                 Handshake
//   request   start, busy, req_*    taken when start is high and busy is low
//   result    rsp_strobe, rsp_*     one word per strobe cycle, cannot stall
//
// A byte request gives its two words, high nibble first; a goto outside the
// display rows and columns gives a lone error word instead. A number is
// converted to BCD bit-serially, then gives a minus sign if negative, skips
// leading zero digits and gives each remaining character as two words.
// Reset is synchronous and clears the state machine and the result strobe.
// The next request can be taken in the same cycle as the last word appears.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_type,
   input  wire logic [7:0]         req_byte_value,
   input  wire logic [7:0]         req_row,
   input  wire logic [7:0]         req_col,
   input  wire logic signed [31:0] req_number,
   output logic                    rsp_strobe,
   output logic                    rsp_drive,
   output logic                    rsp_rs,
   output logic [3:0]              rsp_nibble,
   output logic [14:0]             rsp_wait_before_us,
   output logic [12:0]             rsp_wait_after_us,
   output logic                    rsp_status,
   output logic                    rsp_last
);

   lcdnw_pkg::lcdnw_cmd_type    cmd;
   lcdnw_pkg::lcdnw_status_type status;

   lcdnw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   lcdnw_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_byte_value     (req_byte_value),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_number         (req_number),
      .cmd                (cmd),
      .status             (status),
      .rsp_strobe         (rsp_strobe),
      .rsp_drive          (rsp_drive),
      .rsp_rs             (rsp_rs),
      .rsp_nibble         (rsp_nibble),
      .rsp_wait_before_us (rsp_wait_before_us),
      .rsp_wait_after_us  (rsp_wait_after_us),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire

>>> design/lcdnw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdnw_checker
// Port-level checks of the nibble write sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdnw_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic [2:0]         req_type,
   input wire logic               rsp_strobe,
   input wire logic               rsp_drive,
   input wire logic               rsp_status,
   input wire logic               rsp_last
);

   a_error_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_last && !rsp_drive))
      else $error("An error word is not a lone final status word.");

   a_status_only_is_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_drive) |-> rsp_status)
      else $error("A word without a pulse carries no error status.");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type <= lcdnw_pkg::REQ_CLEAR)) |=> busy)
      else $error("A valid request was accepted but the block did not go busy.");

   a_more_words_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("A request dropped busy before its last word.");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("A word followed the final word of a request at once.");

endmodule

bind char_lcd_nibble_write_sequencer lcdnw_checker u_lcdnw_checker (.*);
`default_nettype wire
